// ===== design/isap_pkg.sv =====
// ----------------------------------------------------------------------------
// isap_pkg
// shared types, codes and constants of the max-flow engine
// ----------------------------------------------------------------------------
package isap_pkg;

    localparam int MAX_NODES_DEF = 512;
    localparam int MAX_EDGES_DEF = 4096;

    localparam int NODE_W = 9;
    localparam int NCNT_W = 10;
    localparam int CAP_W  = 31;
    localparam int FLOW_W = 32;
    localparam int OP_W   = 2;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int ALU_W  = 32;

    localparam logic [CAP_W-1:0] CAP_MAX = 31'h7fffffff;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_RUN    = 2'd2;

    localparam logic [1:0] REG_SOURCE = 2'd0;
    localparam logic [1:0] REG_SINK   = 2'd1;
    localparam logic [1:0] REG_NCOUNT = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [NODE_W-1:0] from_node;
        logic [NODE_W-1:0] to_node;
        logic [CAP_W-1:0]  capacity;
    } cmd_t;

    typedef struct packed {
        logic [FLOW_W-1:0] max_flow;
        logic              edge_overflow;
    } result_t;

    typedef struct packed {
        logic [NODE_W-1:0] source_node;
        logic [NODE_W-1:0] sink_node;
        logic [NCNT_W-1:0] node_count;
    } cfg_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef enum logic [5:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INS_WR1,
        ST_INS_HEAD2,
        ST_INS_WR2,
        ST_INIT_A,
        ST_INIT_B,
        ST_INIT_TOP,
        ST_INIT_ZERO,
        ST_TOP,
        ST_ARC,
        ST_SCAN,
        ST_CHK1,
        ST_CHK2,
        ST_AUG_P,
        ST_AUG_C,
        ST_AUG_R,
        ST_AUG_M,
        ST_UPD_P,
        ST_UPD_C,
        ST_UPD_R,
        ST_UPD_W1,
        ST_UPD_W2,
        ST_RL_HEAD,
        ST_RL_LOAD,
        ST_RL_SCAN,
        ST_RL_CHK1,
        ST_RL_CHK2,
        ST_RL_POP,
        ST_RL_DEC,
        ST_RL_SET,
        ST_RL_INC,
        ST_RL_BACK,
        ST_DONE
    } state_t;

endpackage

// ===== design/isap_ram.sv =====
// ----------------------------------------------------------------------------
// isap_ram
// single write port, single registered read port memory
// ----------------------------------------------------------------------------
module isap_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem_reg [D];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/isap_alu.sv =====
// ----------------------------------------------------------------------------
// isap_alu
// shared add, subtract and compare unit used by the steps of the sequencer
// ----------------------------------------------------------------------------
module isap_alu (
    input  isap_pkg::alu_op_t          op,
    input  logic [isap_pkg::ALU_W-1:0] a,
    input  logic [isap_pkg::ALU_W-1:0] b,
    output logic [isap_pkg::ALU_W:0]   sum,
    output logic                       lt
);

    always_comb
    begin
        unique case (op)
            isap_pkg::ALU_ADD: sum = {1'b0, a} + {1'b0, b};
            isap_pkg::ALU_SUB: sum = {1'b0, a} - {1'b0, b};
            default:           sum = '0;
        endcase
    end

    assign lt = a < b;

endmodule

// ===== design/isap_regs.sv =====
// ----------------------------------------------------------------------------
// isap_regs
// configuration registers behind the apb port
// ----------------------------------------------------------------------------
module isap_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [isap_pkg::ADDR_W-1:0] paddr,
    input  logic [isap_pkg::DATA_W-1:0] pwdata,
    output logic [isap_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output isap_pkg::cfg_t              cfg
);

    isap_pkg::cfg_t cfg_reg;
    logic [1:0]     idx;

    assign idx    = paddr[3:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_node <= '0;
            cfg_reg.sink_node   <= isap_pkg::NODE_W'(1);
            cfg_reg.node_count  <= isap_pkg::NCNT_W'(512);
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                isap_pkg::REG_SOURCE:
                    cfg_reg.source_node <= pwdata[isap_pkg::NODE_W-1:0];
                isap_pkg::REG_SINK:
                    cfg_reg.sink_node <= pwdata[isap_pkg::NODE_W-1:0];
                isap_pkg::REG_NCOUNT:
                    cfg_reg.node_count <= pwdata[isap_pkg::NCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            isap_pkg::REG_SOURCE: prdata = isap_pkg::DATA_W'(cfg_reg.source_node);
            isap_pkg::REG_SINK:   prdata = isap_pkg::DATA_W'(cfg_reg.sink_node);
            isap_pkg::REG_NCOUNT: prdata = isap_pkg::DATA_W'(cfg_reg.node_count);
            default:              prdata = '0;
        endcase
    end

endmodule

// ===== design/max_flow_isap_engine.sv =====
// ----------------------------------------------------------------------------
// max_flow_isap_engine
// isap maximum flow with current-arc and gap heuristics over ram edge lists
// ----------------------------------------------------------------------------
// channel  | signals                               | transaction
// command  | start, busy, cmd                      | start high while busy low
// result   | done, result                          | done high for one cycle
// config   | psel, penable, pwrite, paddr, pwdata  | access phase with pready
//
// after reset and after each clear all MAX_NODES list heads are swept to nil
// an insert does two list-head reads, each followed by an edge write
// a run first sets up the n configured nodes, then does edge visits, path steps
// and relabels, all through one alu and rams with one write and one read port
// the strobe is registered from ST_DONE after the walk; it cannot be stalled
module max_flow_isap_engine #(
    parameter int MAX_NODES = isap_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = isap_pkg::MAX_EDGES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  isap_pkg::cmd_t              cmd,
    output logic                        busy,
    output logic                        done,
    output isap_pkg::result_t           result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [isap_pkg::ADDR_W-1:0] paddr,
    input  logic [isap_pkg::DATA_W-1:0] pwdata,
    output logic [isap_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int LW = $clog2(MAX_NODES + 1);
    localparam int EW = $clog2(MAX_EDGES);
    localparam int NODE_W = isap_pkg::NODE_W;
    localparam int CAP_W = isap_pkg::CAP_W;
    localparam int ALU_W = isap_pkg::ALU_W;
    localparam logic [EW:0] NIL = (EW+1)'(MAX_EDGES);

    isap_pkg::cfg_t cfg;

    isap_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // memories
    logic              tgt_we, res_we, lnk_we, head_we, carc_we, dist_we, pop_we, pred_we;
    logic [EW-1:0]     tgt_wa, res_wa, lnk_wa, tgt_ra, res_ra, lnk_ra;
    logic [NODE_W-1:0] tgt_wd, tgt_rd, pred_wd, pred_rd;
    logic [CAP_W-1:0]  res_wd, res_rd;
    logic [EW:0]       lnk_wd, lnk_rd, head_wd, head_rd, carc_wd, carc_rd;
    logic [NW-1:0]     head_wa, head_ra, carc_wa, carc_ra, dist_wa, dist_ra;
    logic [NW-1:0]     pred_wa, pred_ra;
    logic [LW-1:0]     dist_wd, dist_rd, pop_wa, pop_ra, pop_wd, pop_rd;

    isap_ram #(.W(NODE_W), .D(MAX_EDGES)) u_tgt (
        .clk(clk), .we(tgt_we), .waddr(tgt_wa), .wdata(tgt_wd), .raddr(tgt_ra), .rdata(tgt_rd)
    );
    isap_ram #(.W(CAP_W), .D(MAX_EDGES)) u_res (
        .clk(clk), .we(res_we), .waddr(res_wa), .wdata(res_wd), .raddr(res_ra), .rdata(res_rd)
    );
    isap_ram #(.W(EW+1), .D(MAX_EDGES)) u_lnk (
        .clk(clk), .we(lnk_we), .waddr(lnk_wa), .wdata(lnk_wd), .raddr(lnk_ra), .rdata(lnk_rd)
    );
    isap_ram #(.W(EW+1), .D(MAX_NODES)) u_head (
        .clk(clk), .we(head_we), .waddr(head_wa), .wdata(head_wd), .raddr(head_ra),
        .rdata(head_rd)
    );
    isap_ram #(.W(EW+1), .D(MAX_NODES)) u_carc (
        .clk(clk), .we(carc_we), .waddr(carc_wa), .wdata(carc_wd), .raddr(carc_ra),
        .rdata(carc_rd)
    );
    isap_ram #(.W(LW), .D(MAX_NODES)) u_dist (
        .clk(clk), .we(dist_we), .waddr(dist_wa), .wdata(dist_wd), .raddr(dist_ra),
        .rdata(dist_rd)
    );
    isap_ram #(.W(LW), .D(MAX_NODES + 1)) u_pop (
        .clk(clk), .we(pop_we), .waddr(pop_wa), .wdata(pop_wd), .raddr(pop_ra), .rdata(pop_rd)
    );
    isap_ram #(.W(NODE_W), .D(MAX_NODES)) u_pred (
        .clk(clk), .we(pred_we), .waddr(pred_wa), .wdata(pred_wd), .raddr(pred_ra),
        .rdata(pred_rd)
    );

    // shared alu
    isap_pkg::alu_op_t alu_op;
    logic [ALU_W-1:0]  alu_a, alu_b;
    logic [ALU_W:0]    alu_sum;
    logic              alu_lt;

    isap_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .sum (alu_sum),
        .lt  (alu_lt)
    );

    // sequencer registers
    isap_pkg::state_t  state_reg, state_next;
    logic [LW-1:0]     i_reg, i_next, du_reg, du_next, ds_reg, ds_next, m_reg, m_next;
    logic [NODE_W-1:0] u_reg, u_next, v_reg, v_next, x_reg, x_next, p_reg, p_next;
    logic [EW:0]       e_reg, e_next, l_reg, l_next, fill_reg, fill_next;
    logic [EW-1:0]     a_reg, a_next;
    logic [CAP_W-1:0]  b_reg, b_next;
    logic [isap_pkg::FLOW_W-1:0] total_reg, total_next;
    logic              ovf_reg, ovf_next, done_reg, done_next;
    isap_pkg::cmd_t    cmd_reg, cmd_next;
    isap_pkg::result_t result_reg, result_next;

    logic [LW-1:0]     n;
    logic [NODE_W-1:0] src, snk;
    logic              bad_run, bad_node, full, v_ok;
    logic [LW-1:0]     nd;

    assign src = cfg.source_node;
    assign snk = cfg.sink_node;
    assign n   = (32'(cfg.node_count) > MAX_NODES) ? LW'(MAX_NODES) : LW'(cfg.node_count);
    assign bad_run = (32'(n) < 2) || (32'(src) >= 32'(n)) || (32'(snk) >= 32'(n))
                     || (src == snk);
    assign bad_node = (32'(cmd.from_node) >= MAX_NODES) || (32'(cmd.to_node) >= MAX_NODES);
    assign full = (32'(fill_reg) + 2) > MAX_EDGES;
    assign v_ok = (32'(tgt_rd) < 32'(n)) && (res_rd != '0);
    assign nd = (alu_sum[ALU_W-1:0] > 32'(n)) ? n : LW'(alu_sum[ALU_W-1:0]);

    assign busy   = state_reg != isap_pkg::ST_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= isap_pkg::ST_CLEAR;
            i_reg     <= '0;
            fill_reg  <= '0;
            ovf_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            fill_reg  <= fill_next;
            ovf_reg   <= ovf_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        du_reg     <= du_next;
        ds_reg     <= ds_next;
        m_reg      <= m_next;
        u_reg      <= u_next;
        v_reg      <= v_next;
        x_reg      <= x_next;
        p_reg      <= p_next;
        e_reg      <= e_next;
        l_reg      <= l_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        total_reg  <= total_next;
        cmd_reg    <= cmd_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        du_next     = du_reg;
        ds_next     = ds_reg;
        m_next      = m_reg;
        u_next      = u_reg;
        v_next      = v_reg;
        x_next      = x_reg;
        p_next      = p_reg;
        e_next      = e_reg;
        l_next      = l_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        total_next  = total_reg;
        fill_next   = fill_reg;
        ovf_next    = ovf_reg;
        cmd_next    = cmd_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        tgt_we = 1'b0; tgt_wa = fill_reg[EW-1:0]; tgt_wd = '0; tgt_ra = e_reg[EW-1:0];
        res_we = 1'b0; res_wa = fill_reg[EW-1:0]; res_wd = '0; res_ra = e_reg[EW-1:0];
        lnk_we = 1'b0; lnk_wa = fill_reg[EW-1:0]; lnk_wd = '0; lnk_ra = e_reg[EW-1:0];
        head_we = 1'b0; head_wa = NW'(u_reg); head_wd = NIL; head_ra = NW'(u_reg);
        carc_we = 1'b0; carc_wa = NW'(u_reg); carc_wd = e_reg; carc_ra = NW'(u_reg);
        dist_we = 1'b0; dist_wa = NW'(u_reg); dist_wd = '0; dist_ra = NW'(u_reg);
        pop_we = 1'b0; pop_wa = du_reg; pop_wd = '0; pop_ra = du_reg;
        pred_we = 1'b0; pred_wa = NW'(v_reg); pred_wd = u_reg; pred_ra = NW'(x_reg);

        alu_op = isap_pkg::ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;

        unique case (state_reg)
            isap_pkg::ST_CLEAR:
            begin
                head_we = 1'b1;
                head_wa = i_reg[NW-1:0];
                head_wd = NIL;
                if (32'(i_reg) == MAX_NODES - 1)
                begin
                    i_next     = '0;
                    state_next = isap_pkg::ST_IDLE;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end

            isap_pkg::ST_IDLE:
            begin
                cmd_next = cmd;
                head_ra  = NW'(cmd.from_node);
                if (start)
                begin
                    case (cmd.opcode)
                        isap_pkg::OP_CLEAR:
                        begin
                            i_next     = '0;
                            fill_next  = '0;
                            ovf_next   = 1'b0;
                            state_next = isap_pkg::ST_CLEAR;
                        end
                        isap_pkg::OP_INSERT:
                        begin
                            if (!bad_node)
                            begin
                                if (full)
                                begin
                                    ovf_next = 1'b1;
                                end
                                else
                                begin
                                    state_next = isap_pkg::ST_INS_WR1;
                                end
                            end
                        end
                        isap_pkg::OP_RUN:
                        begin
                            total_next = '0;
                            if (bad_run)
                            begin
                                done_next   = 1'b1;
                                result_next = '{max_flow: '0, edge_overflow: ovf_reg};
                            end
                            else
                            begin
                                i_next     = '0;
                                ds_next    = '0;
                                u_next     = src;
                                pred_we    = 1'b1;
                                pred_wa    = NW'(src);
                                pred_wd    = src;
                                state_next = isap_pkg::ST_INIT_A;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            isap_pkg::ST_INS_WR1:
            begin
                tgt_we     = 1'b1;
                tgt_wd     = cmd_reg.to_node;
                res_we     = 1'b1;
                res_wd     = cmd_reg.capacity;
                lnk_we     = 1'b1;
                lnk_wd     = head_rd;
                head_we    = 1'b1;
                head_wa    = NW'(cmd_reg.from_node);
                head_wd    = fill_reg;
                fill_next  = fill_reg + 1'b1;
                state_next = isap_pkg::ST_INS_HEAD2;
            end

            isap_pkg::ST_INS_HEAD2:
            begin
                head_ra    = NW'(cmd_reg.to_node);
                state_next = isap_pkg::ST_INS_WR2;
            end

            isap_pkg::ST_INS_WR2:
            begin
                tgt_we     = 1'b1;
                tgt_wd     = cmd_reg.from_node;
                res_we     = 1'b1;
                res_wd     = '0;
                lnk_we     = 1'b1;
                lnk_wd     = head_rd;
                head_we    = 1'b1;
                head_wa    = NW'(cmd_reg.to_node);
                head_wd    = fill_reg;
                fill_next  = fill_reg + 1'b1;
                state_next = isap_pkg::ST_IDLE;
            end

            isap_pkg::ST_INIT_A:
            begin
                head_ra    = i_reg[NW-1:0];
                dist_we    = 1'b1;
                dist_wa    = i_reg[NW-1:0];
                dist_wd    = '0;
                pop_we     = 1'b1;
                pop_wa     = i_reg;
                pop_wd     = '0;
                state_next = isap_pkg::ST_INIT_B;
            end

            isap_pkg::ST_INIT_B:
            begin
                carc_we = 1'b1;
                carc_wa = i_reg[NW-1:0];
                carc_wd = head_rd;
                if (i_reg + 1'b1 == n)
                begin
                    state_next = isap_pkg::ST_INIT_TOP;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = isap_pkg::ST_INIT_A;
                end
            end

            isap_pkg::ST_INIT_TOP:
            begin
                pop_we     = 1'b1;
                pop_wa     = n;
                pop_wd     = '0;
                state_next = isap_pkg::ST_INIT_ZERO;
            end

            isap_pkg::ST_INIT_ZERO:
            begin
                pop_we     = 1'b1;
                pop_wa     = '0;
                pop_wd     = n;
                state_next = isap_pkg::ST_TOP;
            end

            isap_pkg::ST_TOP:
            begin
                if (ds_reg >= n)
                begin
                    state_next = isap_pkg::ST_DONE;
                end
                else
                begin
                    state_next = isap_pkg::ST_ARC;
                end
            end

            isap_pkg::ST_ARC:
            begin
                e_next     = carc_rd;
                du_next    = dist_rd;
                state_next = isap_pkg::ST_SCAN;
            end

            isap_pkg::ST_SCAN:
            begin
                if (e_reg == NIL)
                begin
                    carc_we    = 1'b1;
                    carc_wd    = NIL;
                    state_next = isap_pkg::ST_RL_HEAD;
                end
                else
                begin
                    state_next = isap_pkg::ST_CHK1;
                end
            end

            isap_pkg::ST_CHK1:
            begin
                v_next  = tgt_rd;
                l_next  = lnk_rd;
                dist_ra = NW'(tgt_rd);
                if (v_ok)
                begin
                    state_next = isap_pkg::ST_CHK2;
                end
                else
                begin
                    e_next     = lnk_rd;
                    state_next = isap_pkg::ST_SCAN;
                end
            end

            isap_pkg::ST_CHK2:
            begin
                alu_op = isap_pkg::ALU_ADD;
                alu_a  = ALU_W'(dist_rd);
                alu_b  = ALU_W'(1);
                if (alu_sum[ALU_W-1:0] == ALU_W'(du_reg))
                begin
                    carc_we = 1'b1;
                    carc_wd = e_reg;
                    pred_we = 1'b1;
                    u_next  = v_reg;
                    if (v_reg == snk)
                    begin
                        x_next     = snk;
                        b_next     = isap_pkg::CAP_MAX;
                        state_next = isap_pkg::ST_AUG_P;
                    end
                    else
                    begin
                        state_next = isap_pkg::ST_TOP;
                    end
                end
                else
                begin
                    e_next     = l_reg;
                    state_next = isap_pkg::ST_SCAN;
                end
            end

            isap_pkg::ST_AUG_P:
            begin
                if (x_reg == src)
                begin
                    x_next     = snk;
                    state_next = isap_pkg::ST_UPD_P;
                end
                else
                begin
                    state_next = isap_pkg::ST_AUG_C;
                end
            end

            isap_pkg::ST_AUG_C:
            begin
                p_next     = pred_rd;
                carc_ra    = NW'(pred_rd);
                state_next = isap_pkg::ST_AUG_R;
            end

            isap_pkg::ST_AUG_R:
            begin
                a_next     = carc_rd[EW-1:0];
                res_ra     = carc_rd[EW-1:0];
                state_next = isap_pkg::ST_AUG_M;
            end

            isap_pkg::ST_AUG_M:
            begin
                alu_a = ALU_W'(res_rd);
                alu_b = ALU_W'(b_reg);
                if (alu_lt)
                begin
                    b_next = res_rd;
                end
                x_next     = p_reg;
                state_next = isap_pkg::ST_AUG_P;
            end

            isap_pkg::ST_UPD_P:
            begin
                alu_op = isap_pkg::ALU_ADD;
                alu_a  = total_reg;
                alu_b  = ALU_W'(b_reg);
                if (x_reg == src)
                begin
                    total_next = alu_sum[ALU_W] ? '1 : alu_sum[ALU_W-1:0];
                    u_next     = src;
                    state_next = isap_pkg::ST_TOP;
                end
                else
                begin
                    state_next = isap_pkg::ST_UPD_C;
                end
            end

            isap_pkg::ST_UPD_C:
            begin
                p_next     = pred_rd;
                carc_ra    = NW'(pred_rd);
                state_next = isap_pkg::ST_UPD_R;
            end

            isap_pkg::ST_UPD_R:
            begin
                a_next     = carc_rd[EW-1:0];
                res_ra     = carc_rd[EW-1:0];
                state_next = isap_pkg::ST_UPD_W1;
            end

            isap_pkg::ST_UPD_W1:
            begin
                alu_op     = isap_pkg::ALU_SUB;
                alu_a      = ALU_W'(res_rd);
                alu_b      = ALU_W'(b_reg);
                res_we     = 1'b1;
                res_wa     = a_reg;
                res_wd     = alu_sum[CAP_W-1:0];
                res_ra     = {a_reg[EW-1:1], ~a_reg[0]};
                state_next = isap_pkg::ST_UPD_W2;
            end

            isap_pkg::ST_UPD_W2:
            begin
                alu_op     = isap_pkg::ALU_ADD;
                alu_a      = ALU_W'(res_rd);
                alu_b      = ALU_W'(b_reg);
                res_we     = 1'b1;
                res_wa     = {a_reg[EW-1:1], ~a_reg[0]};
                res_wd     = alu_sum[CAP_W-1:0];
                x_next     = p_reg;
                state_next = isap_pkg::ST_UPD_P;
            end

            isap_pkg::ST_RL_HEAD:
            begin
                m_next     = n;
                state_next = isap_pkg::ST_RL_LOAD;
            end

            isap_pkg::ST_RL_LOAD:
            begin
                e_next     = head_rd;
                state_next = isap_pkg::ST_RL_SCAN;
            end

            isap_pkg::ST_RL_SCAN:
            begin
                if (e_reg == NIL)
                begin
                    state_next = isap_pkg::ST_RL_POP;
                end
                else
                begin
                    state_next = isap_pkg::ST_RL_CHK1;
                end
            end

            isap_pkg::ST_RL_CHK1:
            begin
                v_next  = tgt_rd;
                l_next  = lnk_rd;
                dist_ra = NW'(tgt_rd);
                if (v_ok)
                begin
                    state_next = isap_pkg::ST_RL_CHK2;
                end
                else
                begin
                    e_next     = lnk_rd;
                    state_next = isap_pkg::ST_RL_SCAN;
                end
            end

            isap_pkg::ST_RL_CHK2:
            begin
                alu_a = ALU_W'(dist_rd);
                alu_b = ALU_W'(m_reg);
                if (alu_lt)
                begin
                    carc_we = 1'b1;
                    carc_wd = e_reg;
                    m_next  = dist_rd;
                end
                e_next     = l_reg;
                state_next = isap_pkg::ST_RL_SCAN;
            end

            isap_pkg::ST_RL_POP:
            begin
                state_next = isap_pkg::ST_RL_DEC;
            end

            isap_pkg::ST_RL_DEC:
            begin
                alu_op = isap_pkg::ALU_SUB;
                alu_a  = ALU_W'(pop_rd);
                alu_b  = ALU_W'(1);
                pop_we = 1'b1;
                pop_wd = alu_sum[LW-1:0];
                // gap: no node left at this label
                if (alu_sum[LW-1:0] == '0)
                begin
                    state_next = isap_pkg::ST_DONE;
                end
                else
                begin
                    state_next = isap_pkg::ST_RL_SET;
                end
            end

            isap_pkg::ST_RL_SET:
            begin
                alu_op  = isap_pkg::ALU_ADD;
                alu_a   = ALU_W'(m_reg);
                alu_b   = ALU_W'(1);
                dist_we = 1'b1;
                dist_wd = nd;
                if (u_reg == src)
                begin
                    ds_next = nd;
                end
                m_next     = nd;
                pop_ra     = nd;
                state_next = isap_pkg::ST_RL_INC;
            end

            isap_pkg::ST_RL_INC:
            begin
                alu_op     = isap_pkg::ALU_ADD;
                alu_a      = ALU_W'(pop_rd);
                alu_b      = ALU_W'(1);
                pop_we     = 1'b1;
                pop_wa     = m_reg;
                pop_wd     = alu_sum[LW-1:0];
                pred_ra    = NW'(u_reg);
                state_next = isap_pkg::ST_RL_BACK;
            end

            isap_pkg::ST_RL_BACK:
            begin
                u_next     = pred_rd;
                state_next = isap_pkg::ST_TOP;
            end

            isap_pkg::ST_DONE:
            begin
                done_next   = 1'b1;
                result_next = '{max_flow: total_reg, edge_overflow: ovf_reg};
                state_next  = isap_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = isap_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
